/* rtl/tvd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_pkg
// types, constants and decode helpers for the typed value converter
// ---------------------------------------------------------------------------
package tvd_pkg;

  localparam int unsigned TypeW  = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ValueW = 64;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PosW   = 5;   // bit position inside the 32-bit magnitude
  localparam int unsigned FracW  = 6;   // fraction width 0..35

  localparam logic [ValueW-1:0] QnanBits = 64'h7FF8_0000_0000_0000;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_TYPE = 2'd1,
    STAT_BAD_LEN  = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // decoded request, passed from the decode stage to the normalize stage
  typedef struct packed {
    kind_e             kind;
    stat_e             status;
    logic              neg;        // sign bit applies
    logic [DataW-1:0]  mag;        // magnitude, right aligned
    logic [FracW-1:0]  frac;
    logic [DataW-1:0]  fbits;      // byte-reversed float bits
  } dec_t;

  function automatic logic [5:0] hex_digit(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = 6'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h5A) r = 6'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h7A) r = 6'(c - 8'h61 + 8'd10);
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // decimal width from two chars; returns the value, and 8'hFF for a nonzero negative width
  function automatic logic [7:0] dec_width(input logic [7:0] c2, input logic [7:0] c3);
    logic [7:0] ch [2];
    logic [1:0] i;
    logic       neg;
    logic [7:0] v;
    ch[0] = c2;
    ch[1] = c3;
    i     = '0;
    neg   = 1'b0;
    v     = '0;
    if (is_blank(ch[0])) begin
      i = 2'd1;
      if (is_blank(ch[1])) i = 2'd2;
    end
    if (i < 2'd2 && (ch[i[0]] == 8'h2B || ch[i[0]] == 8'h2D)) begin
      neg = ch[i[0]] == 8'h2D;
      i   = i + 2'd1;
    end
    if (i < 2'd2 && is_digit(ch[i[0]])) begin
      v = ch[i[0]] - 8'h30;
      i = i + 2'd1;
      if (i < 2'd2 && is_digit(ch[i[0]])) v = 8'(v * 8'd10 + (ch[i[0]] - 8'h30));
    end
    // any nonzero negative width is out of range; 8'hFF marks it
    if (neg && v != 8'd0) v = 8'hFF;
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/tvd_decode.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_decode
// type code parse, width check and magnitude extraction
// ---------------------------------------------------------------------------
module tvd_decode (
  input  wire logic [tvd_pkg::TypeW-1:0] type_code_i,
  input  wire logic [tvd_pkg::DataW-1:0] data_word_i,
  output tvd_pkg::dec_t                  dec_o
);
  import tvd_pkg::*;

  logic [7:0] c0, c1, c2, c3;
  logic [7:0] total;
  logic       is_fix, is_flt, is_int, sgn;
  logic [DataW-1:0] shifted;

  assign c0 = type_code_i[31:24];
  assign c1 = type_code_i[23:16];
  assign c2 = type_code_i[15:8];
  assign c3 = type_code_i[7:0];

  always_comb begin
    is_fix = (c0 == 8'h73 || c0 == 8'h66) && c1 == 8'h70;
    is_flt = c0 == 8'h66 && c1 == 8'h6C && c2 == 8'h74;
    is_int = (c0 == 8'h73 || c0 == 8'h75) && c1 == 8'h69;
    sgn    = c0 == 8'h73;
    total  = '0;
    dec_o  = '0;
    dec_o.fbits = {data_word_i[7:0], data_word_i[15:8], data_word_i[23:16],
                   data_word_i[31:24]};
    dec_o.frac  = hex_digit(c3);
    if (is_fix) begin
      total = 8'(hex_digit(c2)) + 8'(hex_digit(c3)) + 8'(sgn);
    end else if (is_int) begin
      total = dec_width(c2, c3);
      dec_o.frac = '0;
    end
    shifted = data_word_i >> (6'd32 - total[5:0]);
    if (is_flt) begin
      dec_o.kind   = KIND_FLOAT;
      dec_o.status = STAT_OK;
    end else if (!is_fix && !is_int) begin
      dec_o.kind   = KIND_ERROR;
      dec_o.status = STAT_BAD_TYPE;
    end else if (total < 8'd1 || total > 8'd32) begin
      dec_o.kind   = KIND_ERROR;
      dec_o.status = STAT_BAD_LEN;
    end else begin
      dec_o.kind   = KIND_FIXED;
      dec_o.status = STAT_OK;
      dec_o.neg    = sgn && data_word_i[31];
      dec_o.mag    = shifted;
      if (sgn) dec_o.mag[5'(total - 8'd1)] = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/tvd_lzc.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tvd_lzc
// leading-one position of a 32-bit word
// ---------------------------------------------------------------------------
module tvd_lzc (
  input  wire logic [tvd_pkg::DataW-1:0] word_i,
  output logic      [tvd_pkg::PosW-1:0]  pos_o,
  output logic                           zero_o
);
  import tvd_pkg::*;

  always_comb begin
    pos_o  = '0;
    zero_o = word_i == '0;
    for (int i = 0; i < DataW; i++) begin
      if (word_i[i]) pos_o = PosW'(i);
    end
  end

endmodule

`default_nettype wire

/* rtl/typed_value_to_double.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// typed_value_to_double
// converts a typed four-byte value into IEEE double bits with a status
// ---------------------------------------------------------------------------
// Fully pipelined: one request per cycle unless stalled; a request passes through
// decode, leading-one search, and shift and pack into the output register. The
// three stages advance together; a stall at the output holds the whole pipe
// and the input stall follows it only when the last stage is full.
module typed_value_to_double (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic [tvd_pkg::TypeW-1:0]     type_code_i,
  input  wire logic [tvd_pkg::DataW-1:0]     data_word_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic      [tvd_pkg::ValueW-1:0]    value_bits_o,
  output logic      [tvd_pkg::StatW-1:0]     status_o
);
  import tvd_pkg::*;

  logic  v1_q, v2_q, v3_q;
  dec_t  dec_d, s1_d, s1_q, s2_q;
  logic  [PosW-1:0] pos_d, pos_q;
  logic  zero_d, zero_q;
  logic  [ValueW-1:0] val_d, val_q;
  logic  [StatW-1:0]  st_d, st_q;
  logic  adv;

  // whole pipe moves unless the output holds a result that is stalled
  assign adv     = !(v3_q && stall_i);
  assign stall_o = !adv;

  tvd_decode u_dec (.type_code_i(type_code_i), .data_word_i(data_word_i), .dec_o(dec_d));

  // float subnormal search reuses the lzc on the fraction field
  always_comb begin
    s1_d = dec_d;
    if (dec_d.kind == KIND_FLOAT) s1_d.mag = {9'd0, dec_d.fbits[22:0]};
  end

  tvd_lzc u_lzc (.word_i(s1_q.mag), .pos_o(pos_d), .zero_o(zero_d));

  // pack stage
  always_comb begin
    logic [7:0]  e;
    logic [22:0] m;
    logic [10:0] ex;
    logic [63:0] sh;
    e     = s2_q.fbits[30:23];
    m     = s2_q.fbits[22:0];
    ex    = '0;
    sh    = '0;
    val_d = QnanBits;
    st_d  = s2_q.status;
    case (s2_q.kind)
      KIND_FIXED: begin
        sh = {32'd0, s2_q.mag} << (6'd52 - 6'(pos_q));
        if (zero_q) val_d = '0;
        else val_d = {1'b0, 11'(11'd1023 + 11'(pos_q) - 11'(s2_q.frac)), sh[51:0]};
        val_d[63] = s2_q.neg;
      end
      KIND_FLOAT: begin
        if (e == 8'hFF) begin
          // nan keeps its payload with the quiet bit forced on
          val_d = {s2_q.fbits[31], 11'h7FF, (m != '0) | m[22], m[21:0], 29'd0};
        end else if (e == 8'h00) begin
          if (m == '0) val_d = {s2_q.fbits[31], 63'd0};
          else begin
            // subnormal: leading one sits at pos_q of the 23-bit fraction
            sh = {41'd0, m} << (6'd23 - 6'(pos_q));
            ex = 11'(11'd1023 - 11'd126 - (11'd23 - 11'(pos_q)));
            val_d = {s2_q.fbits[31], ex, sh[22:0], 29'd0};
          end
        end else begin
          val_d = {s2_q.fbits[31], 11'(11'(e) + 11'd896), m, 29'd0};
        end
      end
      default: val_d = QnanBits;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= s1_d;
      s2_q   <= s1_q;
      pos_q  <= pos_d;
      zero_q <= zero_d;
      val_q  <= val_d;
      st_q   <= st_d;
    end
  end

  assign valid_o      = v3_q;
  assign value_bits_o = val_q;
  assign status_o     = st_q;

`ifndef SYNTH
  // a held result must not change under stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_bits_o) && $stable(status_o))
    else $error("result changed under stall");
  // errors always carry the quiet nan
  a_err_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != STAT_OK |-> value_bits_o == QnanBits)
    else $error("error result without nan");
  // input is stalled exactly when the output stage is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("stall mismatch");
`endif

endmodule

`default_nettype wire
